// ===== rtl/core/mpbs_pkg.sv =====
// mpbs_pkg: shared constants, codes and types of the multi-pattern byte scanner
// depends on nothing; imported by every module of the block
package mpbs_pkg;

  localparam int MAX_PATTERNS    = 8;
  localparam int MAX_PATTERN_LEN = 32;
  localparam int SLOT_W = $clog2(MAX_PATTERNS);
  localparam int POS_W  = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int ROW_W  = MAX_PATTERN_LEN * 8;
  localparam int CNT_W  = 4;

  // command codes of an input beat
  typedef enum logic [1:0] {
    CMD_LOAD_BYTE = 2'd0,
    CMD_SET_LEN   = 2'd1,
    CMD_SCAN      = 2'd2,
    CMD_FINISH    = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  // result kinds
  localparam logic KIND_MATCH  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RPT
  } state_t;

  // control of the scan window
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [POS_W-1:0] idx;
    logic [7:0]       data;
  } win_ctl_t;

endpackage

// ===== rtl/core/mpbs_pattern_mem.sv =====
// mpbs_pattern_mem: pattern table, one row of bytes per pattern slot
// byte-wide writes, whole-row registered read; uses mpbs_pkg
module mpbs_pattern_mem import mpbs_pkg::*; (
  input  logic              clk,
  input  logic              wr,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [POS_W-1:0]  wr_pos,
  input  logic [7:0]        wr_data,
  input  logic              rd,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic [ROW_W-1:0]  rd_row
);

  logic [ROW_W-1:0] mem [MAX_PATTERNS];

  // byte write into a row
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_slot][{wr_pos, 3'b000} +: 8] <= wr_data;
    end
  end

  // registered row read
  always_ff @(posedge clk) begin
    if (rd) begin
      rd_row <= mem[rd_slot];
    end
  end

endmodule

// ===== rtl/core/mpbs_matcher.sv =====
// mpbs_matcher: circular window of scanned bytes and the row compare
// compares one pattern row against the window at a start offset; uses mpbs_pkg
module mpbs_matcher import mpbs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  win_ctl_t         ctl,
  input  logic [POS_W-1:0] start,
  input  logic [ROW_W-1:0] row,
  input  logic [LEN_W-1:0] len,
  output logic             hit
);

  logic [7:0] window [MAX_PATTERN_LEN];
  logic [MAX_PATTERN_LEN-1:0] ok;

  // window storage
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
        window[k] <= 8'd0;
      end
    end else if (ctl.wr) begin
      window[ctl.idx] <= ctl.data;
    end
  end

  // per-byte compare, bytes past the length always pass
  always_comb begin
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      ok[j] = (window[start + POS_W'(j)] == row[j*8 +: 8]) ||
              (LEN_W'(j) >= len);
    end
  end

  assign hit = &ok;

endmodule

// ===== rtl/core/multi_pattern_byte_scanner_unit.sv =====
// multi_pattern_byte_scanner_unit: top level, command sequencer, counts, result register
// depends on mpbs_pkg, mpbs_pattern_mem and mpbs_matcher
//
//   channel  | signals                                   | direction
//   input    | in_valid, in_stall, cmd .. data_byte      | in, stall out
//   result   | out_valid, out_stall, kind .. last        | out, stall in
//   config   | cfg_write, cfg_index, cfg_data            | in, always taken
//
// load and set-length beats leave the sequencer idle. a scan beat stores its byte, and
// when a position is tested the patterns are tried one at a time (up to 8) until
// the first hit; the first row is read at the accepting edge and the single row
// read port of the pattern table sets the rate. finish reports each active
// pattern in turn. reset is synchronous and needs no clearing pass. a stalled
// result holds the sequencer until it drains.
module multi_pattern_byte_scanner_unit import mpbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [2:0]  pattern_slot,
  input  logic [4:0]  byte_position,
  input  logic [5:0]  length_value,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [2:0]  which_pattern,
  output logic [31:0] match_address,
  output logic [31:0] match_count,
  output logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;
  logic [31:0] base_address;
  logic [3:0]  active_patterns;
  logic [31:0] bytes_seen;
  logic [31:0] pos;
  logic [SLOT_W-1:0] idx;
  logic [LEN_W-1:0]  lengths [MAX_PATTERNS];
  logic [31:0]       counts [MAX_PATTERNS];

  logic in_fire, out_free, hit, is_last_idx;
  logic [CNT_W-1:0] n;
  logic [LEN_W-1:0] need;
  logic [31:0] seen_next;
  logic [31:0] cnt_inc;
  logic scan_test, rd, match_load, rpt_load, rpt_done, cmp_step;
  logic [SLOT_W-1:0] rd_slot;
  logic [ROW_W-1:0]  row;
  win_ctl_t win_ctl;
  cmd_t cmd_in;

  assign cmd_in   = cmd_t'(cmd);
  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // clamp of the active count
  always_comb begin
    if (active_patterns == 4'd0) begin
      n = CNT_W'(1);
    end else if (active_patterns > CNT_W'(MAX_PATTERNS)) begin
      n = CNT_W'(MAX_PATTERNS);
    end else begin
      n = active_patterns;
    end
  end

  // longest active pattern
  always_comb begin
    need = LEN_W'(1);
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      if (CNT_W'(i) < n && lengths[i] > need) begin
        need = lengths[i];
      end
    end
  end

  assign seen_next   = bytes_seen + 32'd1;
  assign scan_test   = seen_next >= {{(32-LEN_W){1'b0}}, need};
  assign is_last_idx = ({1'b0, idx} + CNT_W'(1)) == n;
  assign cnt_inc     = (counts[idx] == '1) ? counts[idx] : counts[idx] + 32'd1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && cmd_in == CMD_SCAN && scan_test) begin
          state_next = S_CMP;
        end else if (in_fire && cmd_in == CMD_FINISH) begin
          state_next = S_RPT;
        end
      end
      S_CMP: begin
        if ((hit && out_free) || (!hit && is_last_idx)) begin
          state_next = S_IDLE;
        end
      end
      S_RPT: begin
        if (out_free && is_last_idx) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    rd         = 1'b0;
    rd_slot    = '0;
    match_load = 1'b0;
    rpt_load   = 1'b0;
    rpt_done   = 1'b0;
    cmp_step   = 1'b0;
    unique case (state)
      S_IDLE: begin
        rd = in_fire && cmd_in == CMD_SCAN;
      end
      S_CMP: begin
        match_load = hit && out_free;
        cmp_step   = !hit && !is_last_idx;
        rd         = cmp_step;
        rd_slot    = idx + SLOT_W'(1);
      end
      S_RPT: begin
        rpt_load = out_free;
        rpt_done = out_free && is_last_idx;
      end
      default: ;
    endcase
  end

  // window control
  always_comb begin
    win_ctl.wr   = in_fire && cmd_in == CMD_SCAN;
    win_ctl.clr  = rpt_done;
    win_ctl.idx  = bytes_seen[POS_W-1:0];
    win_ctl.data = data_byte;
  end

  mpbs_pattern_mem u_mem (
    .clk     (clk),
    .wr      (in_fire && cmd_in == CMD_LOAD_BYTE),
    .wr_slot (pattern_slot),
    .wr_pos  (byte_position),
    .wr_data (data_byte),
    .rd      (rd),
    .rd_slot (rd_slot),
    .rd_row  (row)
  );

  mpbs_matcher u_match (
    .clk   (clk),
    .rst   (rst),
    .ctl   (win_ctl),
    .start (pos[POS_W-1:0]),
    .row   (row),
    .len   (lengths[idx]),
    .hit   (hit)
  );

  // state, configuration, scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      base_address    <= 32'd0;
      active_patterns <= 4'd1;
      bytes_seen      <= 32'd0;
      idx             <= '0;
    end else begin
      state <= state_next;
      if (cfg_write && cfg_index == REG_BASE) begin
        base_address <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_ACTIVE) begin
        active_patterns <= cfg_data[3:0];
      end
      if (rpt_done) begin
        bytes_seen <= 32'd0;
      end else if (win_ctl.wr) begin
        bytes_seen <= seen_next;
      end
      if (in_fire) begin
        idx <= '0;
      end else if (cmp_step || (rpt_load && !rpt_done)) begin
        idx <= idx + SLOT_W'(1);
      end
    end
  end

  // start offset of the tested position
  always_ff @(posedge clk) begin
    if (win_ctl.wr) begin
      pos <= seen_next - {{(32-LEN_W){1'b0}}, need};
    end
  end

  // pattern lengths, saturated to the row size
  always_ff @(posedge clk) begin
    if (in_fire && cmd_in == CMD_SET_LEN) begin
      lengths[pattern_slot] <= (length_value > LEN_W'(MAX_PATTERN_LEN)) ?
                               LEN_W'(MAX_PATTERN_LEN) : length_value;
    end
  end

  // match counters
  always_ff @(posedge clk) begin
    if (rst || rpt_done) begin
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        counts[i] <= 32'd0;
      end
    end else if (match_load) begin
      counts[idx] <= cnt_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (match_load || rpt_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (match_load) begin
      kind          <= KIND_MATCH;
      which_pattern <= idx;
      match_address <= base_address + pos;
      match_count   <= cnt_inc;
      last          <= 1'b1;
    end else if (rpt_load) begin
      kind          <= KIND_REPORT;
      which_pattern <= idx;
      match_address <= 32'd0;
      match_count   <= counts[idx];
      last          <= is_last_idx;
    end
  end

  // a new result only comes out of the compare or report sequence
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) != S_IDLE)
    else $error("result appeared while idle");

  // report index stays within the active patterns
  a_rpt_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_RPT |-> ({1'b0, idx} < n))
    else $error("report index beyond active count");

  // finishing clears the scan
  a_clear: assert property (@(posedge clk) disable iff (rst)
    rpt_done |=> bytes_seen == 32'd0 && counts[0] == 32'd0)
    else $error("scan not cleared after finish");

  // a compare only follows at least one scanned byte
  a_cmp_seen: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> bytes_seen != 32'd0)
    else $error("compare without scanned byte");

endmodule

// ===== dv/tb_multi_pattern_byte_scanner_unit.sv =====
// tb_multi_pattern_byte_scanner_unit: self-checking bench for the byte scanner
// drives load, length, scan and finish beats, predicts matches and count reports
// depends on mpbs_pkg and multi_pattern_byte_scanner_unit
module tb_multi_pattern_byte_scanner_unit;
  import mpbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int FILL_LEN       = 5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_LOAD_BYTE;
  logic [2:0]  pattern_slot = '0;
  logic [4:0]  byte_position = '0;
  logic [5:0]  length_value = 6'd1;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [2:0]  which_pattern;
  logic [31:0] match_address;
  logic [31:0] match_count;
  logic        last;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_BASE;
  logic [31:0] cfg_data = '0;

  multi_pattern_byte_scanner_unit dut (.*);

  always #4 clk = ~clk;

  typedef struct packed {
    logic        kind;
    logic [2:0]  which;
    logic [31:0] addr;
    logic [31:0] count;
    logic        last;
  } result_t;

  typedef struct {
    cmd_t        op;
    logic [2:0]  slot;
    logic [4:0]  bpos;
    logic [5:0]  len;
    logic [7:0]  data;
    bit          typed;   // expected result typed in below
    result_t     res;
  } stim_t;

  // predictor state
  logic [7:0]  pat_mem [MAX_PATTERNS][MAX_PATTERN_LEN];
  logic [5:0]  pat_len [MAX_PATTERNS];
  logic [31:0] hits [MAX_PATTERNS];
  logic [7:0]  window [MAX_PATTERN_LEN];
  logic [31:0] seen;
  logic [31:0] base_addr;
  logic [3:0]  active_reg;

  result_t expected_results[$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      timed_out = 1'b0;

  function automatic int active_slots();
    int n;
    n = active_reg;
    if (n == 0) n = 1;
    if (n > MAX_PATTERNS) n = MAX_PATTERNS;
    return n;
  endfunction

  function automatic void clear_scan_state();
    for (int i = 0; i < MAX_PATTERNS; i++) hits[i] = '0;
    for (int i = 0; i < MAX_PATTERN_LEN; i++) window[i] = '0;
    seen = '0;
  endfunction

  // advance the predictor by one beat and queue what it causes
  function automatic void predict_beat(cmd_t op, logic [2:0] slot, logic [4:0] bpos,
                                       logic [5:0] len, logic [7:0] data);
    int n;
    int need;
    logic [31:0] pos;
    bit ok;
    result_t r;
    n = active_slots();
    case (op)
      CMD_LOAD_BYTE: pat_mem[slot][bpos] = data;
      CMD_SET_LEN: pat_len[slot] = (len > MAX_PATTERN_LEN) ? 6'(MAX_PATTERN_LEN) : len;
      CMD_SCAN: begin
        window[seen % MAX_PATTERN_LEN] = data;
        seen = seen + 1;
        need = 1;
        for (int i = 0; i < n; i++) if (pat_len[i] > need) need = pat_len[i];
        if (seen >= need) begin
          pos = seen - need;
          for (int i = 0; i < n; i++) begin
            ok = 1'b1;
            for (int j = 0; j < pat_len[i]; j++)
              if (window[(pos + j) % MAX_PATTERN_LEN] != pat_mem[i][j]) ok = 1'b0;
            if (ok) begin
              if (hits[i] != '1) hits[i]++;
              r = '{KIND_MATCH, 3'(i), base_addr + pos, hits[i], 1'b1};
              expected_results.push_back(r);
              break;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < n; i++) begin
          r = '{KIND_REPORT, 3'(i), 32'd0, hits[i], i == n - 1};
          expected_results.push_back(r);
        end
        clear_scan_state();
      end
    endcase
  endfunction

  // input side: one beat with a random gap ahead, valid stays up after accept
  task automatic send_beat(cmd_t op, logic [2:0] slot, logic [4:0] bpos,
                           logic [5:0] len, logic [7:0] data);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= op;
    pattern_slot  <= slot;
    byte_position <= bpos;
    length_value  <= len;
    data_byte     <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(op, slot, bpos, len, data);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && !timed_out) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_BASE) base_addr = value;
    else active_reg = value[3:0];
    @(negedge clk);
  endtask

  // load a pattern of given length into a slot
  task automatic load_pattern(int slot, int len, ref logic [7:0] bytes[MAX_PATTERN_LEN]);
    send_beat(CMD_SET_LEN, 3'(slot), 5'd0, 6'(len), 8'd0);
    for (int j = 0; j < len; j++)
      send_beat(CMD_LOAD_BYTE, 3'(slot), 5'(j), 6'd0, bytes[j]);
  endtask

  // output side: random stall, check each result beat
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall && $urandom_range(0, 2) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, kind); errors++;
        end
        if (which_pattern !== e.which) begin
          $error("which_pattern exp %0d got %0d", e.which, which_pattern); errors++;
        end
        if (match_address !== e.addr) begin
          $error("match_address exp %h got %h", e.addr, match_address); errors++;
        end
        if (match_count !== e.count) begin
          $error("match_count exp %0d got %0d", e.count, match_count); errors++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_multi_pattern_byte_scanner_unit failed");
      $finish;
    end
  end

  stim_t directed[$];
  logic [7:0] pbytes[MAX_PATTERN_LEN];

  initial begin
    stim_t s;
    int queued;
    int len;
    base_addr = '0;
    active_reg = 4'd1;
    clear_scan_state();
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      pat_len[i] = '0;
      for (int j = 0; j < MAX_PATTERN_LEN; j++) pat_mem[i][j] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the leading bytes of every slot so no unwritten entry is ever read
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      for (int j = 0; j < FILL_LEN; j++) pbytes[j] = 8'($urandom);
      load_pattern(i, FILL_LEN, pbytes);
    end
    wait_idle();
    write_reg(REG_BASE, 32'hFFFF_FFFE);
    write_reg(REG_ACTIVE, 4'd1);

    // directed table: one-byte pattern 0x00 then 0xff, wrapping base address
    directed.push_back('{CMD_SET_LEN, 3'd0, 5'd0, 6'd1, 8'h00, 1'b0, '0});
    directed.push_back('{CMD_LOAD_BYTE, 3'd0, 5'd0, 6'd0, 8'h00, 1'b0, '0});
    directed.push_back('{CMD_SCAN, 3'd0, 5'd0, 6'd0, 8'h00, 1'b1,
                         '{KIND_MATCH, 3'd0, 32'hFFFF_FFFE, 32'd1, 1'b1}});
    directed.push_back('{CMD_SCAN, 3'd7, 5'd31, 6'd63, 8'h00, 1'b1,
                         '{KIND_MATCH, 3'd0, 32'hFFFF_FFFF, 32'd2, 1'b1}});
    directed.push_back('{CMD_SCAN, 3'd0, 5'd0, 6'd0, 8'h00, 1'b1,
                         '{KIND_MATCH, 3'd0, 32'h0000_0000, 32'd3, 1'b1}});
    directed.push_back('{CMD_SCAN, 3'd0, 5'd0, 6'd0, 8'hFF, 1'b0, '0});
    directed.push_back('{CMD_FINISH, 3'd0, 5'd0, 6'd0, 8'h00, 1'b1,
                         '{KIND_REPORT, 3'd0, 32'd0, 32'd3, 1'b1}});
    directed.push_back('{CMD_LOAD_BYTE, 3'd0, 5'd0, 6'd0, 8'hFF, 1'b0, '0});
    directed.push_back('{CMD_SCAN, 3'd0, 5'd0, 6'd0, 8'hFF, 1'b0, '0});
    // length zero matches everywhere, length above max saturates
    directed.push_back('{CMD_SET_LEN, 3'd0, 5'd0, 6'd0, 8'h00, 1'b0, '0});
    directed.push_back('{CMD_SCAN, 3'd0, 5'd0, 6'd0, 8'h5A, 1'b0, '0});
    directed.push_back('{CMD_SET_LEN, 3'd7, 5'd0, 6'd63, 8'h00, 1'b0, '0});
    directed.push_back('{CMD_SET_LEN, 3'd1, 5'd0, 6'd32, 8'h00, 1'b0, '0});
    directed.push_back('{CMD_SCAN, 3'd0, 5'd0, 6'd0, 8'hA5, 1'b0, '0});
    directed.push_back('{CMD_FINISH, 3'd5, 5'd17, 6'd40, 8'h3C, 1'b0, '0});
    // bring the long slots back within the filled bytes
    directed.push_back('{CMD_SET_LEN, 3'd7, 5'd0, 6'd4, 8'h00, 1'b0, '0});
    directed.push_back('{CMD_SET_LEN, 3'd1, 5'd0, 6'd4, 8'h00, 1'b0, '0});
    foreach (directed[k]) begin
      s = directed[k];
      if (s.typed) wait_idle();
      queued = expected_results.size();
      send_beat(s.op, s.slot, s.bpos, s.len, s.data);
      if (s.typed && (expected_results.size() != queued + 1 ||
                      expected_results[queued] != s.res)) begin
        $error("predictor disagrees with typed row %0d", k);
        errors++;
      end
    end
    wait_idle();
    write_reg(REG_ACTIVE, 4'd8);
    write_reg(REG_BASE, 32'd0);
    send_beat(CMD_SCAN, 3'd0, 5'd0, 6'd0, 8'h11);
    send_beat(CMD_FINISH, 3'd0, 5'd0, 6'd0, 8'h00);
    wait_idle();

    // random phases: short patterns, scans drawn mostly from pattern bytes
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ACTIVE, (ph == 0) ? 4'd15 : (ph == 1) ? 4'd0 : 4'($urandom_range(1, 8)));
      write_reg(REG_BASE, 32'($urandom));
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          len = $urandom_range(0, 4);
          for (int j = 0; j < len; j++) pbytes[j] = 8'($urandom_range(0, 3));
          load_pattern(i, len, pbytes);
        end
      end
      for (int b = 0; b < 30; b++) begin
        case ($urandom_range(0, 19))
          0: send_beat(CMD_LOAD_BYTE, 3'($urandom), 5'($urandom), 6'($urandom),
                       8'($urandom_range(0, 3)));
          1: send_beat(CMD_SET_LEN, 3'($urandom), 5'($urandom),
                       6'($urandom_range(0, 5)), 8'($urandom));
          2: send_beat(CMD_FINISH, 3'($urandom), 5'($urandom), 6'($urandom), 8'($urandom));
          3: send_beat(CMD_SCAN, 3'($urandom), 5'($urandom), 6'($urandom), 8'($urandom));
          default: send_beat(CMD_SCAN, 3'($urandom), 5'($urandom), 6'($urandom),
                             8'($urandom_range(0, 3)));
        endcase
      end
      send_beat(CMD_FINISH, 3'd0, 5'd0, 6'd0, 8'd0);
      wait_idle();
    end

    wait_idle();
    if (errors == 0 && !timed_out) begin
      $display("tb_multi_pattern_byte_scanner_unit passed");
    end else begin
      $display("tb_multi_pattern_byte_scanner_unit failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mpbs_pkg.sv
rtl/core/mpbs_pattern_mem.sv
rtl/core/mpbs_matcher.sv
rtl/core/multi_pattern_byte_scanner_unit.sv
dv/tb_multi_pattern_byte_scanner_unit.sv
